>>> sv/rrts_pkg.sv
// rrts_pkg: shared types, constants and the microcode ROM of the round-robin task scheduler.
// No dependencies; imported by round_robin_task_scheduler_top and tb_top.
package rrts_pkg;

    localparam int MAX_TASKS = 8;
    localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int IN_W      = 136;  // 130 payload bits, padded to bytes
    localparam int OUT_W     = 72;   // 70 payload bits, padded to bytes

    localparam logic [31:0] MIN_STACK_WORDS = 32'd128;
    localparam logic [31:0] FRAME_BYTES     = 32'd64;

    typedef logic [SLOT_W-1:0] slot_t;

    // Slot states
    typedef enum logic [1:0] {
        ST_UNUSED  = 2'd0,
        ST_READY   = 2'd1,
        ST_BLOCKED = 2'd2
    } slot_state_t;

    // Operations
    typedef enum logic [1:0] {
        FN_CREATE = 2'd0,
        FN_TICK   = 2'd1,
        FN_SELECT = 2'd2,
        FN_DELAY  = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_BAD_ARGS = 2'd1,
        STS_FULL     = 2'd2,
        STS_NO_READY = 2'd3
    } status_t;

    localparam slot_t LAST_SLOT = slot_t'(MAX_TASKS - 1);

    // Microcode
    typedef logic [3:0] upc_t;

    localparam upc_t UA_FETCH   = 4'd0;
    localparam upc_t UA_C_CHK   = 4'd1;
    localparam upc_t UA_C_SCAN  = 4'd2;
    localparam upc_t UA_C_TAKE  = 4'd3;
    localparam upc_t UA_T_INIT  = 4'd4;
    localparam upc_t UA_T_SCAN  = 4'd5;
    localparam upc_t UA_S_INIT  = 4'd6;
    localparam upc_t UA_S_SCAN  = 4'd7;
    localparam upc_t UA_D_INIT  = 4'd8;
    localparam upc_t UA_D_WRITE = 4'd9;
    localparam upc_t UA_DONE    = 4'd10;

    // Datapath operation of one step
    typedef enum logic [3:0] {
        U_FETCH,
        U_CCHK,
        U_CSCAN,
        U_CTAKE,
        U_TINIT,
        U_TSCAN,
        U_SINIT,
        U_SSCAN,
        U_DINIT,
        U_DWRITE,
        U_DONE
    } uop_t;

    // Jump condition of one step
    typedef enum logic [2:0] {
        C_DISPATCH,   // on accept jump to the entry point of func
        C_ALWAYS,
        C_NEVER,
        C_BADARG,
        C_UNUSED,     // slot at scan index is unused
        C_READY,      // slot at scan index is ready
        C_DSKIP,      // delay blocks nothing
        C_OUT_FREE    // output register can take the result
    } cond_t;

    // cond true -> jt; else loop and not last slot -> same step; else -> jf
    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        logic  loop;
        upc_t  jt;
        upc_t  jf;
    } ucode_t;

    function automatic ucode_t ucode_rom(input upc_t a);
        ucode_t w;
        begin
            unique case (a)
                UA_FETCH:   w = '{U_FETCH,  C_DISPATCH, 1'b0, UA_FETCH,   UA_FETCH};
                UA_C_CHK:   w = '{U_CCHK,   C_BADARG,   1'b0, UA_DONE,    UA_C_SCAN};
                UA_C_SCAN:  w = '{U_CSCAN,  C_UNUSED,   1'b1, UA_C_TAKE,  UA_DONE};
                UA_C_TAKE:  w = '{U_CTAKE,  C_ALWAYS,   1'b0, UA_DONE,    UA_DONE};
                UA_T_INIT:  w = '{U_TINIT,  C_ALWAYS,   1'b0, UA_T_SCAN,  UA_T_SCAN};
                UA_T_SCAN:  w = '{U_TSCAN,  C_NEVER,    1'b1, UA_DONE,    UA_DONE};
                UA_S_INIT:  w = '{U_SINIT,  C_ALWAYS,   1'b0, UA_S_SCAN,  UA_S_SCAN};
                UA_S_SCAN:  w = '{U_SSCAN,  C_READY,    1'b1, UA_DONE,    UA_DONE};
                UA_D_INIT:  w = '{U_DINIT,  C_DSKIP,    1'b0, UA_DONE,    UA_D_WRITE};
                UA_D_WRITE: w = '{U_DWRITE, C_ALWAYS,   1'b0, UA_DONE,    UA_DONE};
                UA_DONE:    w = '{U_DONE,   C_OUT_FREE, 1'b0, UA_FETCH,   UA_DONE};
                default:    w = '{U_FETCH,  C_ALWAYS,   1'b0, UA_FETCH,   UA_FETCH};
            endcase
            return w;
        end
    endfunction

    function automatic upc_t dispatch_entry(input func_t f);
        upc_t a;
        begin
            unique case (f)
                FN_CREATE: a = UA_C_CHK;
                FN_TICK:   a = UA_T_INIT;
                FN_SELECT: a = UA_S_INIT;
                FN_DELAY:  a = UA_D_INIT;
            endcase
            return a;
        end
    endfunction

    // Next slot with wrap
    function automatic slot_t slot_inc(input slot_t s);
        begin
            return (s == LAST_SLOT) ? '0 : slot_t'(s + 1'b1);
        end
    endfunction

    // Low three bits of a slot number
    function automatic logic [2:0] to_index(input slot_t s);
        logic [SLOT_W+2:0] ext;
        begin
            ext = {3'b000, s};
            return ext[2:0];
        end
    endfunction

endpackage

>>> sv/round_robin_task_scheduler_top.sv
// Round-robin task scheduler: microcoded sequencer over a table of task slots.
// Depends on rrts_pkg (types, constants, microcode ROM).
//
// Usage:
//   s_axis (tdata) carries one request item: create, tick, select or delay.
//   m_axis (tdata) returns exactly one result item per request.
//   cfg_wr_en/cfg_wr_data write scheduler_running; write only while idle.
// Sequencing:
//   A 4-bit micro-PC steps through a small ROM program. Each control word
//   names a datapath operation and a two-way jump; scan steps loop on the
//   same word while a slot counter walks the table, one slot per cycle.
// Flow: a create with bad args goes from its check to the done step; any
//   other create scans for an unused slot, tick and select scan the table,
//   and delay writes the current slot only when it blocks it. A new item
//   is taken only in the fetch step, after the previous result has left
//   the done step; the slot scan reads one table entry per cycle.
// Reset: all slots unused, delays and tick counter zero, no current task,
//   scheduler not running, m_axis empty.
// Stall: the result waits in the output register; the next item is taken
//   and worked on, and its result waits in the done step until m_axis frees.
module round_robin_task_scheduler_top
    import rrts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] func, [33:2] entry_addr, [65:34] stack_addr,
    // [97:66] stack_len, [129:98] delay_ticks, rest zero
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [1:0] status, [4:2] task_index, [36:5] initial_sp,
    // [68:37] tick_count, [69] switch_request, rest zero
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data
);

    // Sequencer
    upc_t        upc_reg, upc_next;
    ucode_t      word;
    logic        cond_true;
    logic        last;
    logic        in_accept;
    logic        out_free;

    // Scheduler state
    slot_state_t slot_state_reg [MAX_TASKS];
    logic [31:0] slot_delay_reg [MAX_TASKS];
    slot_t       cur_slot_reg;
    logic        cur_valid_reg;
    logic [31:0] tick_reg;
    logic [3:0]  created_reg;
    logic        running_reg;

    // Scan pointers
    slot_t       idx_reg;
    slot_t       cnt_reg;
    slot_state_t rd_state;
    logic [31:0] rd_delay;

    // Captured request
    func_t       func_in;
    logic [31:0] entry_reg;
    logic [31:0] stack_reg;
    logic [31:0] words_reg;
    logic [31:0] ticks_reg;
    logic        bad_args;
    logic [31:0] stack_end;
    logic [31:0] sp_value;

    // Result staging and output register
    status_t     res_status_reg;
    logic [2:0]  res_index_reg;
    logic [31:0] res_sp_reg;
    logic        res_sw_reg;
    logic        out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    assign word      = ucode_rom(upc_reg);
    assign func_in   = func_t'(s_axis_tdata[1:0]);
    assign s_axis_tready = (word.cond == C_DISPATCH);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign last      = (cnt_reg == LAST_SLOT);

    assign rd_state  = slot_state_reg[idx_reg];
    assign rd_delay  = slot_delay_reg[idx_reg];

    assign bad_args  = (entry_reg == 32'd0) || (stack_reg == 32'd0) ||
                       (words_reg < MIN_STACK_WORDS);
    assign stack_end = stack_reg + {words_reg[29:0], 2'b00};
    assign sp_value  = {stack_end[31:3], 3'b000} - FRAME_BYTES;

    // Jump condition select
    always_comb
    begin
        unique case (word.cond)
            C_DISPATCH: cond_true = in_accept;
            C_ALWAYS:   cond_true = 1'b1;
            C_NEVER:    cond_true = 1'b0;
            C_BADARG:   cond_true = bad_args;
            C_UNUSED:   cond_true = (rd_state == ST_UNUSED);
            C_READY:    cond_true = (rd_state == ST_READY);
            C_DSKIP:    cond_true = !running_reg || (ticks_reg == 32'd0) ||
                                    !cur_valid_reg;
            C_OUT_FREE: cond_true = out_free;
        endcase
    end

    // Next micro-PC
    always_comb
    begin
        priority if (word.cond == C_DISPATCH)
        begin
            upc_next = in_accept ? dispatch_entry(func_in) : word.jf;
        end
        else if (cond_true)
        begin
            upc_next = word.jt;
        end
        else if (word.loop && !last)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = word.jf;
        end
    end

    // Control state and slot table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= UA_FETCH;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                slot_state_reg[i] <= ST_UNUSED;
                slot_delay_reg[i] <= 32'd0;
            end
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            tick_reg      <= 32'd0;
            created_reg   <= 4'd0;
            running_reg   <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;

            if (cfg_wr_en)
            begin
                running_reg <= cfg_wr_data;
            end

            if (word.uop == U_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (word.uop)
                U_CCHK:
                begin
                    idx_reg <= '0;
                    cnt_reg <= '0;
                end
                U_CSCAN:
                begin
                    if (rd_state != ST_UNUSED && !last)
                    begin
                        idx_reg <= slot_inc(idx_reg);
                        cnt_reg <= slot_inc(cnt_reg);
                    end
                end
                U_CTAKE:
                begin
                    slot_state_reg[idx_reg] <= ST_READY;
                    slot_delay_reg[idx_reg] <= 32'd0;
                    if (created_reg != 4'd15)
                    begin
                        created_reg <= created_reg + 4'd1;
                    end
                end
                U_TINIT:
                begin
                    tick_reg <= tick_reg + 32'd1;
                    idx_reg  <= '0;
                    cnt_reg  <= '0;
                end
                U_TSCAN:
                begin
                    if (rd_state == ST_BLOCKED && rd_delay != 32'd0)
                    begin
                        slot_delay_reg[idx_reg] <= rd_delay - 32'd1;
                        if (rd_delay == 32'd1)
                        begin
                            slot_state_reg[idx_reg] <= ST_READY;
                        end
                    end
                    idx_reg <= slot_inc(idx_reg);
                    cnt_reg <= slot_inc(cnt_reg);
                end
                U_SINIT:
                begin
                    idx_reg <= cur_valid_reg ? slot_inc(cur_slot_reg) : '0;
                    cnt_reg <= '0;
                end
                U_SSCAN:
                begin
                    if (rd_state == ST_READY)
                    begin
                        cur_slot_reg  <= idx_reg;
                        cur_valid_reg <= 1'b1;
                    end
                    else if (!last)
                    begin
                        idx_reg <= slot_inc(idx_reg);
                        cnt_reg <= slot_inc(cnt_reg);
                    end
                end
                U_DINIT:
                begin
                    idx_reg <= cur_slot_reg;
                end
                U_DWRITE:
                begin
                    slot_delay_reg[idx_reg] <= ticks_reg;
                    slot_state_reg[idx_reg] <= ST_BLOCKED;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Request capture, result staging and output data
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            entry_reg <= s_axis_tdata[33:2];
            stack_reg <= s_axis_tdata[65:34];
            words_reg <= s_axis_tdata[97:66];
            ticks_reg <= s_axis_tdata[129:98];
        end

        unique case (word.uop)
            U_CCHK:
            begin
                res_status_reg <= bad_args ? STS_BAD_ARGS : STS_OK;
                res_index_reg  <= 3'd0;
                res_sp_reg     <= 32'd0;
                res_sw_reg     <= 1'b0;
            end
            U_CSCAN:
            begin
                if (rd_state != ST_UNUSED && last)
                begin
                    res_status_reg <= STS_FULL;
                end
            end
            U_CTAKE:
            begin
                res_index_reg <= to_index(idx_reg);
                res_sp_reg    <= sp_value;
            end
            U_TINIT:
            begin
                res_status_reg <= STS_OK;
                res_index_reg  <= 3'd0;
                res_sp_reg     <= 32'd0;
                res_sw_reg     <= 1'b1;
            end
            U_SINIT:
            begin
                res_status_reg <= STS_OK;
                res_index_reg  <= 3'd0;
                res_sp_reg     <= 32'd0;
                res_sw_reg     <= 1'b0;
            end
            U_SSCAN:
            begin
                if (rd_state == ST_READY)
                begin
                    res_index_reg <= to_index(idx_reg);
                end
                else if (last)
                begin
                    res_status_reg <= STS_NO_READY;
                end
            end
            U_DINIT:
            begin
                res_status_reg <= STS_OK;
                res_index_reg  <= 3'd0;
                res_sp_reg     <= 32'd0;
                res_sw_reg     <= running_reg;
            end
            U_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg <= {2'b00, res_sw_reg, tick_reg, res_sp_reg,
                                     res_index_reg, res_status_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for round_robin_task_scheduler_top (create, tick, select, delay).
// Depends on rrts_pkg and the scheduler RTL; a cycle-free predictor mirrors the slot table.
module tb_top
    import rrts_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 2 * (MAX_TASKS + 3);
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT_ITEM   = 120;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // receiver stall patterns
    localparam int RX_FREE = 0;
    localparam int RX_COIN = 1;
    localparam int RX_SLOW = 2;

    typedef struct {
        logic        drain;  // marker: sender holds until every result is back
        func_t       op;
        logic [31:0] entry;
        logic [31:0] stack;
        logic [31:0] words;
        logic [31:0] ticks;
    } sched_req_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  idx;
        logic [31:0] sp;
        logic [31:0] tcount;
        logic        sw;
    } sched_res_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             cfg_wr_en     = 1'b0;
    logic             cfg_wr_data   = 1'b0;

    round_robin_task_scheduler_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #1 clk = ~clk;

    // Shadow of the slot table and scheduler registers
    slot_state_t slot_st  [MAX_TASKS] = '{default: ST_UNUSED};
    logic [31:0] slot_dly [MAX_TASKS] = '{default: '0};
    int          cur_slot  = 0;
    bit          cur_valid = 1'b0;
    logic [31:0] tick_q    = '0;
    bit          running_q = 1'b0;

    int n_created  = 0;
    int n_selected = 0;
    int n_woken    = 0;

    sched_req_t req_queue [$];   // items waiting for the driver
    sched_res_t due_queue [$];   // predicted results, oldest first
    sched_req_t bus_req;         // item currently offered on s_axis
    bit         in_fire_q = 1'b0;
    int         n_queued  = 0;
    int         n_in      = 0;
    int         n_out     = 0;
    int         err_count = 0;

    int gap_left       = 0;
    int burst_left     = 0;
    int hold_left      = 0;
    int mode_left      = 0;
    int rx_mode        = RX_FREE;
    bit long_hold_done = 1'b0;
    int idle_cycles    = 0;

    // Apply one item to the shadow state and return the result it must produce.
    function automatic sched_res_t schedule_step(sched_req_t r);
        sched_res_t  res;
        int          s;
        int          base;
        bit          found;
        logic [31:0] stack_top;
        res        = '0;
        res.status = STS_OK;
        found      = 1'b0;
        case (r.op)
            FN_CREATE:
            begin
                // argument check wins over a full table
                if (r.entry == 0 || r.stack == 0 || r.words < MIN_STACK_WORDS)
                    res.status = STS_BAD_ARGS;
                else
                begin
                    res.status = STS_FULL;
                    for (s = 0; s < MAX_TASKS; s++)
                        if (!found && slot_st[s] == ST_UNUSED)
                        begin
                            found       = 1'b1;
                            slot_st[s]  = ST_READY;
                            slot_dly[s] = '0;
                            stack_top   = r.stack + (r.words << 2);
                            res.status  = STS_OK;
                            res.idx     = 3'(s);
                            res.sp      = (stack_top & ~32'h7) - FRAME_BYTES;
                            n_created++;
                        end
                end
            end
            FN_TICK:
            begin
                tick_q++;
                for (s = 0; s < MAX_TASKS; s++)
                    if (slot_st[s] == ST_BLOCKED && slot_dly[s] != 0)
                    begin
                        slot_dly[s]--;
                        if (slot_dly[s] == 0)
                        begin
                            slot_st[s] = ST_READY;
                            n_woken++;
                        end
                    end
                res.sw = 1'b1;
            end
            FN_SELECT:
            begin
                // round-robin from the slot after the current one, else from slot 0
                res.status = STS_NO_READY;
                base       = cur_valid ? cur_slot + 1 : 0;
                for (s = 0; s < MAX_TASKS; s++)
                    if (!found && slot_st[(base + s) % MAX_TASKS] == ST_READY)
                    begin
                        found      = 1'b1;
                        cur_slot   = (base + s) % MAX_TASKS;
                        cur_valid  = 1'b1;
                        res.status = STS_OK;
                        res.idx    = 3'(cur_slot);
                        n_selected++;
                    end
            end
            default:
            begin
                // delay: no effect at all while stopped; zero ticks only switches
                if (running_q)
                begin
                    if (r.ticks != 0 && cur_valid)
                    begin
                        slot_dly[cur_slot] = r.ticks;
                        slot_st[cur_slot]  = ST_BLOCKED;
                    end
                    res.sw = 1'b1;
                end
            end
        endcase
        res.tcount = tick_q;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        err_count++;
        $display("%0t result %0d: %s got %h, want %h", $realtime, n_out, what, got, want);
    endtask

    task automatic push_req(func_t op, logic [31:0] entry, logic [31:0] stack,
                            logic [31:0] words, logic [31:0] ticks);
        req_queue.push_back('{1'b0, op, entry, stack, words, ticks});
        n_queued++;
    endtask

    // Mostly well-formed context switches (select, delay, ticks, select) with
    // random content; the rest single random items including creates.
    task automatic push_random_phase(int count, bit wide_delay, bit with_pause);
        int          start;
        int          k;
        int          pick;
        func_t       op;
        logic [31:0] words;
        logic [31:0] ticks;
        start = n_queued;
        while (n_queued - start < count)
        begin
            if (with_pause && n_queued - start >= count / 2)
            begin
                req_queue.push_back('{1'b1, FN_TICK, '0, '0, '0, '0});
                with_pause = 1'b0;
            end
            if ($urandom_range(0, 9) < 6)
            begin
                k = $urandom_range(1, 6);
                push_req(FN_SELECT, $urandom, $urandom, $urandom, $urandom);
                push_req(FN_DELAY, $urandom, $urandom, $urandom,
                         wide_delay ? $urandom : 32'(k));
                repeat ($urandom_range(0, k + 1))
                    push_req(FN_TICK, $urandom, $urandom, $urandom, $urandom);
                push_req(FN_SELECT, $urandom, $urandom, $urandom, $urandom);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                op   = (pick < 15) ? FN_CREATE : (pick < 45) ? FN_TICK :
                       (pick < 75) ? FN_SELECT : FN_DELAY;
                words = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, MIN_STACK_WORDS))
                                                    : $urandom;
                ticks = wide_delay ? $urandom :
                        ($urandom_range(0, 7) == 0) ? '0 : 32'($urandom_range(1, 8));
                push_req(op, ($urandom_range(0, 15) == 0) ? '0 : $urandom,
                         ($urandom_range(0, 15) == 0) ? '0 : $urandom, words, ticks);
            end
        end
    endtask

    // Sampled at rising edges only, where every value read was settled earlier.
    task automatic wait_idle();
        @(posedge clk);
        while (req_queue.size() != 0 || s_axis_tvalid || n_in != n_out)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_running(bit v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        running_q    = v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // Driver: bursts of items with random gaps; new item only once the bus is free.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_fire_q))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (req_queue.size() > 0 && req_queue[0].drain)
            begin
                s_axis_tvalid <= 1'b0;
                if (due_queue.size() == 0)
                    void'(req_queue.pop_front());
            end
            else if (req_queue.size() > 0)
            begin
                bus_req = req_queue.pop_front();
                // 6 pad bits on top of the 130-bit payload
                s_axis_tdata  <= {6'b0, bus_req.ticks, bus_req.words, bus_req.stack,
                                  bus_req.entry, bus_req.op};
                s_axis_tvalid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stall pattern per stretch, plus one long hold-off that
    // backs the block up while the sender keeps offering items.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!long_hold_done && n_in >= HOLD_AT_ITEM)
        begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = $urandom_range(RX_FREE, RX_SLOW);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (rx_mode)
                RX_FREE: m_axis_tready <= 1'b1;
                RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: predicts on input accept, checks on output accept.
    always @(posedge clk)
    begin : monitor
        sched_res_t got;
        sched_res_t want;
        if (rst_n)
        begin
            in_fire_q <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = status_t'(m_axis_tdata[1:0]);
                got.idx    = m_axis_tdata[4:2];
                got.sp     = m_axis_tdata[36:5];
                got.tcount = m_axis_tdata[68:37];
                got.sw     = m_axis_tdata[69];
                if (due_queue.size() == 0)
                    report_mismatch("unexpected result, tdata low", m_axis_tdata[31:0], '0);
                else
                begin
                    want = due_queue.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.idx != want.idx)
                        report_mismatch("task_index", 32'(got.idx), 32'(want.idx));
                    if (got.sp != want.sp)
                        report_mismatch("initial_sp", got.sp, want.sp);
                    if (got.tcount != want.tcount)
                        report_mismatch("tick_count", got.tcount, want.tcount);
                    if (got.sw != want.sw)
                        report_mismatch("switch_request", 32'(got.sw), 32'(want.sw));
                end
                n_out <= n_out + 1;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                due_queue.push_back(schedule_step(bus_req));
                n_in <= n_in + 1;
            end
        end
    end

    // Watchdog: too long without any handshake on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stopped scheduler, empty table
        write_running(1'b0);
        push_req(FN_SELECT, '0, '0, '0, '0);               // nothing ready
        push_req(FN_DELAY, '0, '0, '0, ALL_ONES);          // ignored while stopped
        push_req(FN_TICK, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        push_req(FN_CREATE, '0, 32'h1000, 32'd256, '0);    // entry zero
        push_req(FN_CREATE, 32'h100, '0, 32'd256, '0);     // stack zero
        push_req(FN_CREATE, 32'h100, 32'h1000, MIN_STACK_WORDS - 1, '0);
        wait_idle();

        // Running: delay with no current task, then a hand-built schedule
        write_running(1'b1);
        push_req(FN_DELAY, '0, '0, '0, 32'd3);
        push_req(FN_CREATE, ALL_ONES, ALL_ONES, ALL_ONES, '0); // stack top wraps
        push_req(FN_CREATE, 32'd1, 32'd1, MIN_STACK_WORDS, '0);
        push_req(FN_SELECT, '0, '0, '0, '0);               // first ready: slot 0
        push_req(FN_DELAY, '0, '0, '0, '0);                // switch only
        push_req(FN_DELAY, '0, '0, '0, 32'd1);             // block slot 0
        push_req(FN_SELECT, '0, '0, '0, '0);               // slot 1
        push_req(FN_TICK, '0, '0, '0, '0);                 // slot 0 wakes
        push_req(FN_SELECT, '0, '0, '0, '0);               // wraps to slot 0
        push_req(FN_DELAY, '0, '0, '0, ALL_ONES);          // slot 0 blocked for good
        push_req(FN_SELECT, '0, '0, '0, '0);
        push_req(FN_SELECT, '0, '0, '0, '0);               // only ready task picks itself
        repeat (MAX_TASKS - 2)
            push_req(FN_CREATE, $urandom | 32'd1, $urandom | 32'd1,
                     32'($urandom_range(MIN_STACK_WORDS, 4096)), $urandom);
        push_req(FN_CREATE, 32'h200, 32'h2000, 32'd512, '0);   // table full
        push_req(FN_CREATE, '0, 32'h2000, 32'd512, '0);        // bad args beat full table
        push_req(FN_SELECT, '0, '0, '0, '0);

        push_random_phase(300, 1'b0, 1'b1);
        wait_idle();
        // stopped again: wide delays are harmless here
        write_running(1'b0);
        push_random_phase(90, 1'b1, 1'b0);
        wait_idle();
        write_running(1'b1);
        push_random_phase(90, 1'b0, 1'b0);
        wait_idle();

        $display("covered %0d items: %0d creates, %0d selects found a task, %0d wakeups",
                 n_in, n_created, n_selected, n_woken);
        $display("scheduler run/stop toggled, receiver held off %0d cycles; %0d errors",
                 LONG_HOLD, err_count);
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
